// ===== design/mfb_pkg.sv =====
// Shared command codes and types of the monochrome frame store.
package mfb_pkg;

	typedef logic [1:0] cmd_t;

	localparam cmd_t CMD_PIXEL = 2'd0;
	localparam cmd_t CMD_HLINE = 2'd1;
	localparam cmd_t CMD_VLINE = 2'd2;
	localparam cmd_t CMD_READ  = 2'd3;

endpackage

// ===== design/mono_framebuffer_draw.sv =====
// Monochrome frame store with pixel, line and byte read commands on one memory.
// No new command is taken until the last is finished. A pixel passes accept, memory read,
// write back and end check; a line repeats memory read and write back per pixel and skips
// write back for each pixel off the panel. A read's result is valid after accept, memory read
// and response, later while an earlier result is held in the stalled output register. Reset:
// arst_n clears control state, then a clearing pass zeroes all DEPTH bytes (5000 by default), no input.
module mono_framebuffer_draw #(
	parameter int PANEL_WIDTH  = 200,
	parameter int PANEL_HEIGHT = 200
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_stall,
	input  mfb_pkg::cmd_t command,
	input  logic [7:0]   pos_x,
	input  logic [7:0]   pos_y,
	input  logic [7:0]   run_length,
	input  logic         ink,
	output logic         out_valid,
	input  logic         out_stall,
	output logic [7:0]   read_byte
);
	import mfb_pkg::*;

	localparam int ROW_BYTES = (PANEL_WIDTH + 7) / 8;
	localparam int DEPTH     = ROW_BYTES * PANEL_HEIGHT;
	localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_RD    = 3'd2;
	localparam logic [2:0] ST_WR    = 3'd3;
	localparam logic [2:0] ST_RESP  = 3'd4;

	logic [2:0]    state_q;
	logic [AW-1:0] clr_cnt_q;
	cmd_t          cmd_q;
	logic [8:0]    col_q;
	logic [8:0]    row_q;
	logic [7:0]    left_q;
	logic          ink_q;
	logic          inb_q;
	logic [AW-1:0] addr_q;
	logic [7:0]    mask_q;
	logic          out_valid_q;
	logic [7:0]    read_byte_q;

	logic [7:0]    mem [DEPTH];
	logic [7:0]    rd_data_q;

	logic          in_fire;
	logic          pix_inb;
	logic          byte_inb;
	logic [AW-1:0] addr;
	logic          rd_en;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [7:0]    wr_data;
	logic          out_load;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_fire   = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign read_byte = read_byte_q;

	assign pix_inb  = (col_q < 9'(PANEL_WIDTH)) && (row_q < 9'(PANEL_HEIGHT));
	assign byte_inb = (col_q[8:3] < 6'(ROW_BYTES)) && (row_q < 9'(PANEL_HEIGHT));
	assign addr     = AW'(int'(row_q) * ROW_BYTES + int'(col_q[8:3]));

	always_comb begin
		rd_en = 1'b0;
		if (state_q == ST_RD) begin
			if (cmd_q == CMD_READ) begin
				rd_en = byte_inb;
			end else begin
				rd_en = (left_q != 8'd0) && pix_inb;
			end
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = addr_q;
		wr_data = ink_q ? (rd_data_q & ~mask_q) : (rd_data_q | mask_q);
		unique case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_cnt_q;
				wr_data = 8'd0;
			end
			ST_WR: wr_en = 1'b1;
			default: wr_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[addr];
		end
	end

	assign out_load = (state_q == ST_RESP) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + AW'(1);
					if (clr_cnt_q == AW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					if (cmd_q == CMD_READ) begin
						state_q <= ST_RESP;
					end else if (left_q == 8'd0) begin
						state_q <= ST_IDLE;
					end else if (pix_inb) begin
						state_q <= ST_WR;
					end
				end
				ST_WR: state_q <= ST_RD;
				ST_RESP: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Position and remaining count of the command in progress; a pixel is a line of one.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_q  <= command;
			col_q  <= {1'b0, pos_x};
			row_q  <= {1'b0, pos_y};
			ink_q  <= ink;
			left_q <= (command == CMD_PIXEL) ? 8'd1 : run_length;
		end else if (state_q == ST_RD) begin
			inb_q  <= byte_inb;
			addr_q <= addr;
			mask_q <= 8'h80 >> col_q[2:0];
			// An off-panel pixel is skipped here; one on the panel advances after write back.
			if (cmd_q != CMD_READ && left_q != 8'd0 && !pix_inb) begin
				left_q <= left_q - 8'd1;
				if (cmd_q == CMD_HLINE) begin
					col_q <= col_q + 9'd1;
				end else begin
					row_q <= row_q + 9'd1;
				end
			end
		end else if (state_q == ST_WR) begin
			left_q <= left_q - 8'd1;
			if (cmd_q == CMD_HLINE) begin
				col_q <= col_q + 9'd1;
			end else begin
				row_q <= row_q + 9'd1;
			end
		end
		if (out_load) begin
			read_byte_q <= inb_q ? rd_data_q : 8'd0;
		end
	end

endmodule

// ===== tb/sv/mono_framebuffer_draw_checker.sv =====
// Frame store checker: tracks every drawn pixel and compares each byte read back.
module mono_framebuffer_draw_checker #(
	parameter int PANEL_WIDTH  = 200,
	parameter int PANEL_HEIGHT = 200
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_stall,
	input  mfb_pkg::cmd_t command,
	input  logic [7:0]    pos_x,
	input  logic [7:0]    pos_y,
	input  logic [7:0]    run_length,
	input  logic          ink,
	input  logic          out_valid,
	input  logic          out_stall,
	input  logic [7:0]    read_byte,
	output int            fail_count,
	output int            reads_outstanding
);
	import mfb_pkg::*;

	localparam int ROW_BYTES   = (PANEL_WIDTH + 7) / 8;
	localparam int STORE_BYTES = ROW_BYTES * PANEL_HEIGHT;

	logic [7:0] frame_bytes [STORE_BYTES];
	logic [7:0] read_bytes_due [$];
	int         errors;

	// Off-panel pixels are dropped, never wrapped.
	function automatic void plot_pixel(int col, int row, logic black);
		int         addr;
		logic [7:0] mask;
		if (col >= PANEL_WIDTH || row >= PANEL_HEIGHT) begin
			return;
		end
		addr = row * ROW_BYTES + col / 8;
		mask = 8'h80 >> (col % 8);
		if (black) begin
			frame_bytes[addr] = frame_bytes[addr] & ~mask;
		end else begin
			frame_bytes[addr] = frame_bytes[addr] | mask;
		end
	endfunction

	function automatic logic [7:0] fetch_byte(int x, int y);
		int bcol;
		bcol = x / 8;
		if (bcol < ROW_BYTES && y < PANEL_HEIGHT) begin
			return frame_bytes[y * ROW_BYTES + bcol];
		end
		return 8'h00;
	endfunction

	function automatic void note_error();
		errors++;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (frame_bytes[i]) begin
				frame_bytes[i] = 8'h00;
			end
			read_bytes_due.delete();
			errors = 0;
			fail_count <= 0;
			reads_outstanding <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (read_bytes_due.size() == 0) begin
					if (errors < 10) begin
						$display("[%0t] read_byte %02h returned with no read pending",
							$realtime, read_byte);
					end
					note_error();
				end else begin
					logic [7:0] want;
					want = read_bytes_due.pop_front();
					if (read_byte !== want) begin
						if (errors < 10) begin
							$display("[%0t] read_byte mismatch: expected %02h, got %02h",
								$realtime, want, read_byte);
						end
						note_error();
					end
				end
			end
			if (in_valid && !in_stall) begin
				case (command)
					CMD_PIXEL: plot_pixel(pos_x, pos_y, ink);
					CMD_HLINE: begin
						for (int i = 0; i < run_length; i++) begin
							plot_pixel(pos_x + i, pos_y, ink);
						end
					end
					CMD_VLINE: begin
						for (int i = 0; i < run_length; i++) begin
							plot_pixel(pos_x, pos_y + i, ink);
						end
					end
					CMD_READ: read_bytes_due.push_back(fetch_byte(pos_x, pos_y));
					default: ;
				endcase
			end
			fail_count <= errors;
			reads_outstanding <= read_bytes_due.size();
		end
	end

endmodule

// ===== tb/sv/mono_framebuffer_draw_tb.sv =====
// Stimulus and verdict for the monochrome frame store draw block.
module mono_framebuffer_draw_tb;
	import mfb_pkg::*;

	localparam int PANEL_WIDTH  = 200;
	localparam int PANEL_HEIGHT = 200;
	localparam int RANDOM_ITEMS = 800;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	cmd_t       command;
	logic [7:0] pos_x;
	logic [7:0] pos_y;
	logic [7:0] run_length;
	logic       ink;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] read_byte;
	int         fail_count;
	int         reads_outstanding;
	int         idle_pct;

	mono_framebuffer_draw #(
		.PANEL_WIDTH (PANEL_WIDTH),
		.PANEL_HEIGHT(PANEL_HEIGHT)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.command   (command),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.run_length(run_length),
		.ink       (ink),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.read_byte (read_byte)
	);

	mono_framebuffer_draw_checker #(
		.PANEL_WIDTH (PANEL_WIDTH),
		.PANEL_HEIGHT(PANEL_HEIGHT)
	) u_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.command          (command),
		.pos_x            (pos_x),
		.pos_y            (pos_y),
		.run_length       (run_length),
		.ink              (ink),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.read_byte        (read_byte),
		.fail_count       (fail_count),
		.reads_outstanding(reads_outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(99) < idle_pct);
		end
	end

	// Holds the transaction until the block takes it; idle cycles go in front of it.
	task automatic issue(cmd_t op, logic [7:0] x, logic [7:0] y, logic [7:0] len,
		logic black);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= op;
		pos_x <= x;
		pos_y <= y;
		run_length <= len;
		ink <= black;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
	endtask

	// Coordinates crowd into two windows so reads often land on drawn pixels,
	// one of them straddling the right and bottom panel edges.
	function automatic logic [7:0] pick_coord();
		int r;
		r = $urandom_range(99);
		if (r < 45) begin
			return 8'($urandom_range(23));
		end
		if (r < 70) begin
			return 8'($urandom_range(215, 176));
		end
		return 8'($urandom_range(255));
	endfunction

	function automatic logic [7:0] pick_length();
		int r;
		r = $urandom_range(99);
		if (r < 5) begin
			return 8'($urandom_range(255));
		end
		if (r < 15) begin
			return 8'd0;
		end
		return 8'($urandom_range(24, 1));
	endfunction

	task automatic random_item();
		int   r;
		cmd_t op;
		r = $urandom_range(99);
		if (r < 30) begin
			op = CMD_PIXEL;
		end else if (r < 45) begin
			op = CMD_HLINE;
		end else if (r < 60) begin
			op = CMD_VLINE;
		end else begin
			op = CMD_READ;
		end
		issue(op, pick_coord(), pick_coord(), pick_length(), 1'($urandom_range(1)));
	endtask

	initial begin
		in_valid = 1'b0;
		command = CMD_PIXEL;
		pos_x = 8'd0;
		pos_y = 8'd0;
		run_length = 8'd0;
		ink = 1'b0;
		idle_pct = 28;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// The clearing pass after reset shows up as a long stall on the first transaction.
		issue(CMD_READ, 8'd0, 8'd0, 8'd0, 1'b0);
		issue(CMD_PIXEL, 8'd0, 8'd0, 8'd0, 1'b0);
		issue(CMD_READ, 8'd0, 8'd0, 8'd0, 1'b0);
		issue(CMD_PIXEL, 8'd199, 8'd199, 8'd0, 1'b0);
		issue(CMD_READ, 8'd199, 8'd199, 8'd0, 1'b0);
		issue(CMD_PIXEL, 8'd200, 8'd5, 8'd0, 1'b0);
		issue(CMD_PIXEL, 8'd5, 8'd200, 8'd0, 1'b0);
		issue(CMD_PIXEL, 8'd255, 8'd255, 8'd0, 1'b0);
		issue(CMD_HLINE, 8'd190, 8'd10, 8'd20, 1'b0);
		issue(CMD_READ, 8'd184, 8'd10, 8'd0, 1'b0);
		issue(CMD_READ, 8'd192, 8'd10, 8'd0, 1'b0);
		issue(CMD_VLINE, 8'd3, 8'd190, 8'd255, 1'b0);
		issue(CMD_READ, 8'd0, 8'd199, 8'd0, 1'b0);
		issue(CMD_HLINE, 8'd0, 8'd20, 8'd0, 1'b0);
		issue(CMD_HLINE, 8'd210, 8'd20, 8'd30, 1'b0);
		issue(CMD_READ, 8'd0, 8'd20, 8'd0, 1'b0);
		issue(CMD_PIXEL, 8'd0, 8'd0, 8'd0, 1'b1);
		issue(CMD_READ, 8'd0, 8'd0, 8'd0, 1'b0);
		issue(CMD_HLINE, 8'd0, 8'd50, 8'd255, 1'b0);
		issue(CMD_HLINE, 8'd4, 8'd50, 8'd9, 1'b1);
		issue(CMD_READ, 8'd0, 8'd50, 8'd0, 1'b0);
		issue(CMD_READ, 8'd192, 8'd50, 8'd0, 1'b0);
		issue(CMD_READ, 8'd200, 8'd50, 8'd0, 1'b0);
		issue(CMD_READ, 8'd0, 8'd200, 8'd0, 1'b0);
		issue(CMD_READ, 8'd255, 8'd255, 8'd0, 1'b0);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			idle_pct = (n >= 300 && n < 450) ? 0 : 28;
			random_item();
		end
		in_valid <= 1'b0;
		idle_pct = 28;

		// The outstanding count is a registered copy, so it trails the channels.
		repeat (2) @(posedge clk);
		while (reads_outstanding != 0) begin
			@(posedge clk);
		end
		// Let a long line still being drawn finish before the verdict.
		repeat (540) @(posedge clk);
		if (fail_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin
		#24000000;
		$display("Some tests failed");
		$finish;
	end

endmodule
